// ===== src/edf_pkg.sv =====
// Package for the deadline feasibility checker: function codes, register indexes and defaults.
// Depends on nothing; used by every module of the block.
package edf_pkg;
	localparam int HEAP_DEPTH_DEF = 1024;
	localparam int DAY_BITS_DEF = 16;
	localparam int MAX_CAP_DEF = 16;
	localparam int CAP_W = 5;
	localparam int CNT_W = 11;
	localparam int DL_W = 16;
	localparam int DAYS_PER_WEEK = 7;
	localparam int FIRST_WEEKEND = 5;
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_DAY = 2'd1;
	localparam logic [1:0] FUNC_FIN = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_SKIP = 1'b1;

	// Memory request from the control unit to the heap memory.
	typedef struct packed {
		logic        rd;
		logic [15:0] raddr;
		logic        wr;
		logic [15:0] waddr;
		logic [DL_W-1:0] wdata;
	} edf_mem_req_t;
endpackage

// ===== src/edf_heap_mem.sv =====
// Heap storage: one write port and one read port, registered read.
// Depends on edf_pkg.
module edf_heap_mem #(
	parameter int DEPTH = edf_pkg::HEAP_DEPTH_DEF,
	parameter int AW = 10
) (
	input  logic clk,
	input  edf_pkg::edf_mem_req_t req,
	output logic [edf_pkg::DL_W-1:0] rdata
);
	import edf_pkg::*;
	logic [DL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem_q[req.raddr[AW-1:0]];
		end
	end
endmodule

// ===== src/edf_ctrl.sv =====
// Sequencer of the checker: push sift-up, pop sift-down and day bookkeeping over the heap memory.
// Depends on edf_pkg; drives edf_heap_mem.
module edf_ctrl #(
	parameter int DEPTH = edf_pkg::HEAP_DEPTH_DEF,
	parameter int DAY_BITS = edf_pkg::DAY_BITS_DEF,
	parameter int MAX_CAP = edf_pkg::MAX_CAP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] func,
	input  logic [edf_pkg::DL_W-1:0] deadline,
	input  logic [edf_pkg::CAP_W-1:0] cap_cfg,
	input  logic skip_cfg,
	output edf_pkg::edf_mem_req_t req,
	input  logic [edf_pkg::DL_W-1:0] rdata,
	output logic out_valid,
	input  logic out_stall,
	output logic [edf_pkg::CAP_W-1:0] served,
	output logic [edf_pkg::CNT_W-1:0] pending,
	output logic failed,
	output logic overflow,
	output logic feasible
);
	import edf_pkg::*;

	localparam int KW = 17;

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_UP_TOP, S_POP_TOP, S_POP_CHK, S_POP_LAST,
		S_DN_RDL, S_DN_RDR, S_DN_CMP, S_OUT
	} state_t;

	state_t state_q;
	logic [KW-1:0] cnt_q, k_q, c_q;
	logic [DL_W-1:0] val_q, left_q;
	logic [DAY_BITS-1:0] day_q;
	logic [2:0] wday_q;
	logic fail_q, ovf_q;
	logic [CAP_W-1:0] srv_q, cap_q;
	logic [KW-1:0] up_idx, lc_idx;

	assign up_idx = (k_q - KW'(1)) >> 1;
	assign lc_idx = {k_q[KW-2:0], 1'b1};
	assign in_stall = (state_q != S_IDLE);
	assign pending = CNT_W'(cnt_q);
	assign failed = fail_q;
	assign overflow = ovf_q;

	always_comb begin
		req = '0;
		case (state_q)
			S_UP_RD: begin
				req.rd = 1'b1;
				req.raddr = 16'(up_idx);
			end
			S_POP_TOP: begin
				req.rd = 1'b1;
				req.raddr = '0;
			end
			S_POP_CHK: begin
				req.rd = 1'b1;
				req.raddr = 16'(cnt_q - KW'(1));
			end
			S_DN_RDL: begin
				req.rd = 1'b1;
				req.raddr = 16'(lc_idx);
			end
			S_DN_RDR: begin
				req.rd = 1'b1;
				req.raddr = 16'(lc_idx + KW'(1));
			end
			default: ;
		endcase
		case (state_q)
			S_UP_CMP: begin
				req.wr = 1'b1;
				if (rdata <= val_q) begin
					req.waddr = 16'(k_q);
					req.wdata = val_q;
				end else begin
					req.waddr = 16'(k_q);
					req.wdata = rdata;
				end
			end
			S_UP_TOP: begin
				req.wr = 1'b1;
				req.waddr = '0;
				req.wdata = val_q;
			end
			S_DN_CMP: begin
				req.wr = 1'b1;
				req.waddr = 16'(k_q);
				if (c_q >= cnt_q || (((c_q + KW'(1)) < cnt_q && rdata < left_q) ?
						rdata : left_q) >= val_q) begin
					req.wdata = val_q;
				end else begin
					req.wdata = ((c_q + KW'(1)) < cnt_q && rdata < left_q) ? rdata : left_q;
				end
			end
			default: ;
		endcase
		if (state_q == S_IDLE && in_valid && func == FUNC_ADD &&
				cnt_q < KW'(DEPTH) && cnt_q == '0) begin
			req.wr = 1'b1;
			req.waddr = '0;
			req.wdata = deadline;
		end
		if (state_q == S_DN_RDL && lc_idx >= cnt_q) begin
			req.wr = 1'b1;
			req.waddr = 16'(k_q);
			req.wdata = val_q;
		end
	end

	logic [DL_W-1:0] best;
	logic [KW-1:0] best_idx;
	always_comb begin
		if ((c_q + KW'(1)) < cnt_q && rdata < left_q) begin
			best = rdata;
			best_idx = c_q + KW'(1);
		end else begin
			best = left_q;
			best_idx = c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			day_q <= '0;
			wday_q <= '0;
			fail_q <= 1'b0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			srv_q <= '0;
			served <= '0;
			feasible <= 1'b0;
			cap_q <= '0;
			k_q <= '0;
			c_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						served <= '0;
						feasible <= 1'b0;
						state_q <= S_OUT;
						out_valid <= 1'b1;
						case (func)
							FUNC_ADD: begin
								if (cnt_q >= KW'(DEPTH)) begin
									ovf_q <= 1'b1;
								end else if (cnt_q != '0) begin
									k_q <= cnt_q;
									val_q <= deadline;
									cnt_q <= cnt_q + KW'(1);
									state_q <= S_UP_RD;
									out_valid <= 1'b0;
								end else begin
									cnt_q <= KW'(1);
								end
							end
							FUNC_DAY: begin
								day_q <= day_q + DAY_BITS'(1);
								wday_q <= (wday_q >= 3'(DAYS_PER_WEEK - 1)) ? '0 :
									wday_q + 3'd1;
								srv_q <= '0;
								cap_q <= (32'(cap_cfg) > MAX_CAP) ? CAP_W'(MAX_CAP) : cap_cfg;
								if (!(skip_cfg && wday_q >= 3'(FIRST_WEEKEND)) && !fail_q) begin
									state_q <= S_POP_TOP;
									out_valid <= 1'b0;
								end
							end
							FUNC_FIN: feasible <= !fail_q && cnt_q == '0;
							default: ;
						endcase
					end
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (rdata <= val_q) begin
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else if (up_idx == '0) begin
						state_q <= S_UP_TOP;
					end else begin
						k_q <= up_idx;
						state_q <= S_UP_RD;
					end
				end
				S_UP_TOP: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_POP_TOP: begin
					if (srv_q >= cap_q || cnt_q == '0) begin
						served <= srv_q;
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						state_q <= S_POP_CHK;
					end
				end
				S_POP_CHK: begin
					if (32'(rdata) < 32'(day_q - DAY_BITS'(1))) begin
						fail_q <= 1'b1;
						served <= srv_q;
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						srv_q <= srv_q + CAP_W'(1);
						cnt_q <= cnt_q - KW'(1);
						if (cnt_q == KW'(1)) begin
							state_q <= S_POP_TOP;
						end else begin
							state_q <= S_POP_LAST;
						end
					end
				end
				S_POP_LAST: begin
					k_q <= '0;
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: begin
					if (lc_idx >= cnt_q) begin
						state_q <= S_POP_TOP;
					end else begin
						c_q <= lc_idx;
						state_q <= S_DN_RDR;
					end
				end
				S_DN_RDR: begin
					left_q <= rdata;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (best >= val_q) begin
						state_q <= S_POP_TOP;
					end else begin
						k_q <= best_idx;
						state_q <= S_DN_RDL;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_POP_LAST) begin
				val_q <= rdata;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= KW'(DEPTH))
		else $error("heap count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == S_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n) srv_q <= CAP_W'(MAX_CAP))
		else $error("served count above capacity limit");
	assert property (@(posedge clk) disable iff (!arst_n) $fell(fail_q) |-> 1'b0)
		else $error("failure flag cleared");
endmodule

// ===== src/edf_deadline_feasibility.sv =====
// Top level of the earliest-deadline-first feasibility checker.
// Depends on edf_pkg, edf_ctrl and edf_heap_mem.
// One item is worked at a time. An add sifts the new job up the heap level by level, reading
// each parent through the registered read port of the heap memory, and writes the job to the
// root if it rises that far; a working day tick pops the root and sifts the last job down for
// each job served, up to the capacity. The result then waits in an output register until
// taken.
module edf_deadline_feasibility #(
	parameter int HEAP_DEPTH = edf_pkg::HEAP_DEPTH_DEF,
	parameter int DAY_BITS = edf_pkg::DAY_BITS_DEF,
	parameter int MAX_CAPACITY = edf_pkg::MAX_CAP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [edf_pkg::CAP_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] func,
	input  logic [edf_pkg::DL_W-1:0] deadline,
	output logic out_valid,
	input  logic out_stall,
	output logic [edf_pkg::CAP_W-1:0] served,
	output logic [edf_pkg::CNT_W-1:0] pending,
	output logic failed,
	output logic overflow,
	output logic feasible
);
	import edf_pkg::*;

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

	logic [CAP_W-1:0] cap_q;
	logic skip_q;
	edf_mem_req_t req;
	logic [DL_W-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(1);
			skip_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_CAPACITY) begin
				cap_q <= cfg_data;
			end else if (cfg_index == REG_SKIP) begin
				skip_q <= cfg_data[0];
			end
		end
	end

	edf_ctrl #(.DEPTH(HEAP_DEPTH), .DAY_BITS(DAY_BITS), .MAX_CAP(MAX_CAPACITY)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .func, .deadline,
		.cap_cfg(cap_q), .skip_cfg(skip_q), .req, .rdata,
		.out_valid, .out_stall, .served, .pending, .failed, .overflow, .feasible
	);

	edf_heap_mem #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_mem (.clk, .req, .rdata);
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for edf_deadline_feasibility: directed and random jobs, day ticks
// and finish items, each result checked against an in-bench deadline scheduler model.
// Depends on edf_pkg and the RTL of the block.
module tb;
	import edf_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CAP_MAX = 16;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [1:0] func;
		logic [DL_W-1:0] deadline;
	} job_item_t;

	typedef struct packed {
		logic [CAP_W-1:0] served;
		logic [CNT_W-1:0] pending;
		logic failed;
		logic overflow;
		logic feasible;
	} day_report_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CAP_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic [DL_W-1:0] deadline;
	logic out_valid;
	logic out_stall;
	logic [CAP_W-1:0] served;
	logic [CNT_W-1:0] pending;
	logic failed;
	logic overflow;
	logic feasible;

	edf_deadline_feasibility dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .deadline(deadline),
		.out_valid(out_valid), .out_stall(out_stall), .served(served), .pending(pending),
		.failed(failed), .overflow(overflow), .feasible(feasible)
	);

	// Scheduler state: pending deadlines kept in ascending order.
	logic [DL_W-1:0] sched_jobs[$];
	logic [15:0] sched_day;
	int unsigned sched_weekday;
	logic sched_fail;
	logic sched_ovf;
	logic [CAP_W-1:0] sched_cap;
	logic sched_skip;

	job_item_t pending_jobs[$];
	day_report_t expected_reports[$];
	int unsigned snd_idle_pct;
	int unsigned rcv_idle_pct;
	bit hold_req;
	bit hold_done;
	int unsigned hold_left;
	int unsigned n_errors;
	int unsigned n_reports;
	longint cycles;
	logic [15:0] gen_day;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("** edf_deadline_feasibility: FAILED **");
			$finish;
		end
	end

	function automatic day_report_t schedule_item(job_item_t it);
		day_report_t r;
		int unsigned quota;
		int pos;
		r = '0;
		case (it.func)
			FUNC_ADD: begin
				if (sched_jobs.size() >= DEPTH) begin
					sched_ovf = 1'b1;
				end else begin
					pos = 0;
					while (pos < sched_jobs.size() && sched_jobs[pos] <= it.deadline)
						pos++;
					sched_jobs.insert(pos, it.deadline);
				end
			end
			FUNC_DAY: begin
				quota = (sched_cap > CAP_MAX) ? CAP_MAX : sched_cap;
				if (!(sched_skip && sched_weekday >= FIRST_WEEKEND) && !sched_fail) begin
					while (r.served < quota && sched_jobs.size() > 0) begin
						if (sched_jobs[0] < sched_day) begin
							sched_fail = 1'b1;
							break;
						end
						void'(sched_jobs.pop_front());
						r.served++;
					end
				end
				sched_day = sched_day + 16'd1;
				sched_weekday = (sched_weekday >= DAYS_PER_WEEK - 1) ? 0 : sched_weekday + 1;
			end
			FUNC_FIN: r.feasible = !sched_fail && sched_jobs.size() == 0;
			default: ;
		endcase
		r.pending = CNT_W'(sched_jobs.size());
		r.failed = sched_fail;
		r.overflow = sched_ovf;
		return r;
	endfunction

	// Driver: holds a stalled item, otherwise offers the next queued one unless idling.
	always @(posedge clk or negedge arst_n) begin
		job_item_t nxt;
		bit take;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_ADD;
			deadline <= '0;
		end else begin
			take = 1'b1;
			if (in_valid && !in_stall)
				expected_reports.insert(expected_reports.size(),
					schedule_item(job_item_t'{func, deadline}));
			else if (in_valid)
				take = 1'b0;
			if (take) begin
				if (pending_jobs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					nxt = pending_jobs.pop_front();
					in_valid <= 1'b1;
					func <= nxt.func;
					deadline <= nxt.deadline;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each taken report and drives the output stall.
	always @(posedge clk or negedge arst_n) begin
		day_report_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_reports++;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report served=%0d pending=%0d", $time,
						served, pending);
					n_errors++;
				end else begin
					want = expected_reports.pop_front();
					if ({served, pending, failed, overflow, feasible} != want) begin
						$display("%0t: expected served=%0d pending=%0d failed=%0b ovf=%0b feas=%0b",
							$time, want.served, want.pending, want.failed, want.overflow,
							want.feasible);
						$display("%0t: got served=%0d pending=%0d failed=%0b ovf=%0b feas=%0b",
							$time, served, pending, failed, overflow, feasible);
						n_errors++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 600;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	task automatic queue_job(logic [1:0] f, logic [DL_W-1:0] d);
		pending_jobs.insert(pending_jobs.size(), job_item_t'{f, d});
		if (f == FUNC_DAY)
			gen_day = gen_day + 16'd1;
	endtask

	task automatic drain_all();
		while (pending_jobs.size() > 0 || in_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CAP_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CAPACITY)
			sched_cap = val;
		else
			sched_skip = val[0];
	endtask

	task automatic random_jobs(int unsigned n);
		int unsigned pick;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 46)
				queue_job(FUNC_ADD, DL_W'(gen_day + $urandom_range(40)));
			else if (pick < 94)
				queue_job(FUNC_DAY, DL_W'($urandom));
			else if (pick < 98)
				queue_job(FUNC_FIN, DL_W'($urandom));
			else
				queue_job(FUNC_NONE, DL_W'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CAPACITY;
		cfg_data = '0;
		cycles = 0;
		n_errors = 0;
		n_reports = 0;
		hold_req = 1'b0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		gen_day = 0;
		sched_day = 0;
		sched_weekday = 0;
		sched_fail = 1'b0;
		sched_ovf = 1'b0;
		sched_cap = 1;
		sched_skip = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed start at the reset settings: capacity one, weekends off duty.
		queue_job(FUNC_FIN, 16'hFFFF);
		queue_job(FUNC_NONE, 16'h1234);
		queue_job(FUNC_ADD, 16'h0000);
		queue_job(FUNC_ADD, 16'hFFFF);
		queue_job(FUNC_ADD, 16'hAAAA);
		queue_job(FUNC_ADD, 16'h5555);
		queue_job(FUNC_ADD, 16'h0003);
		queue_job(FUNC_FIN, 16'h0000);
		repeat (8) queue_job(FUNC_DAY, 16'h0000);
		queue_job(FUNC_FIN, 16'h0000);
		drain_all();
		write_reg(REG_CAPACITY, 5'd0);
		queue_job(FUNC_ADD, gen_day + 16'd4);
		repeat (3) queue_job(FUNC_DAY, 16'h0000);
		drain_all();
		write_reg(REG_CAPACITY, 5'd31);
		write_reg(REG_SKIP, 5'd0);
		repeat (20) queue_job(FUNC_ADD, DL_W'(gen_day + $urandom_range(30)));
		repeat (4) queue_job(FUNC_DAY, 16'h0000);
		drain_all();

		snd_idle_pct = 22;
		rcv_idle_pct = 77;
		write_reg(REG_CAPACITY, 5'd3);
		write_reg(REG_SKIP, 5'd1);
		random_jobs(120);
		drain_all();

		snd_idle_pct = 77;
		rcv_idle_pct = 22;
		write_reg(REG_CAPACITY, 5'd1);
		random_jobs(120);
		drain_all();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_reg(REG_CAPACITY, 5'd16);
		write_reg(REG_SKIP, 5'd0);
		hold_req = 1'b1;
		random_jobs(120);
		drain_all();

		// Fill the heap past its depth, serve a few days, then force a missed deadline.
		repeat (DEPTH + 6)
			queue_job(FUNC_ADD, DL_W'(gen_day + 16'd100 + $urandom_range(20000)));
		repeat (10) queue_job(FUNC_DAY, 16'h0000);
		queue_job(FUNC_ADD, 16'h0000);
		queue_job(FUNC_DAY, 16'h0000);
		queue_job(FUNC_DAY, 16'h0000);
		queue_job(FUNC_ADD, gen_day);
		queue_job(FUNC_FIN, 16'h0000);
		drain_all();

		$display("Checked %0d results: adds, day ticks, finish and unused codes under several",
			n_reports);
		$display("capacity and weekend settings, a long output hold-off, overflow and failure.");
		if (n_errors == 0 && expected_reports.size() == 0)
			$display("** edf_deadline_feasibility: PASSED **");
		else
			$display("** edf_deadline_feasibility: FAILED **");
		$finish;
	end
endmodule
